// ----- hw/rtl/ppgagc_pkg.sv -----
// Shared types and constants for the LED auto gain calibration block.
// Used by ppgagc_ctrl, ppgagc_dp and the top level; depends on nothing.
package ppgagc_pkg;

   // field widths
   localparam int CMD_W      = 2;
   localparam int PHASE_W    = 2;
   localparam int DRIVE_W    = 8;
   localparam int LED_DAC_W  = 7;
   localparam int AMB_DAC_W  = 10;
   localparam int ON_TIME_W  = 6;
   localparam int FLAGS_W    = 4;
   localparam int PROD_W     = 24;  // 10000 * (255 + 1023) fits in 24 bits
   localparam int SUM_W      = 11;  // target + ambient code
   localparam int SCALE_W    = 14;
   localparam int RSP_DATA_W = 40;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 2;

   // command codes
   localparam logic [CMD_W-1:0] CMD_SAMPLE  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_START   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;
   localparam logic [CMD_W-1:0] CMD_UNUSED  = 2'd3;

   // calibration phases
   localparam logic [PHASE_W-1:0] PH_START   = 2'd0;
   localparam logic [PHASE_W-1:0] PH_CURRENT = 2'd1;
   localparam logic [PHASE_W-1:0] PH_DAC     = 2'd2;
   localparam logic [PHASE_W-1:0] PH_DONE    = 2'd3;

   // register update flags: bit0 drive, bit1 LED DAC, bit2 ambient DAC, bit3 on-time
   localparam logic [FLAGS_W-1:0] FLAGS_NONE    = 4'b0000;
   localparam logic [FLAGS_W-1:0] FLAGS_LED_DAC = 4'b0010;
   localparam logic [FLAGS_W-1:0] FLAGS_ALL     = 4'b1111;

   // arithmetic constants
   localparam int AMB_BASE     = 280000;
   localparam int SCALE        = 10000;
   localparam int LED_MARGIN   = 128;
   localparam int LED_HIGH     = 320000;
   localparam int LED_LOW      = 200000;
   localparam int LED_DAC_TOP  = 120;
   localparam int AMB_DAC_MAX  = 1023;
   localparam int ON_TIME_INIT = 5;
   localparam int ON_TIME_CAL  = 32;

   // register indexes
   localparam logic [REG_IDX_W-1:0] REG_TARGET_IDAC  = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_MAX_CURRENT  = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_LOW_BATTERY  = 2'd2;
   localparam logic [REG_IDX_W-1:0] REG_INIT_CURRENT = 2'd3;

   typedef struct packed {
      logic [7:0] target_idac;
      logic [7:0] max_current;
      logic       low_battery;
      logic [7:0] init_current;
   } cfg_type;

   typedef enum logic [1:0] {
      DIV_AMB   = 2'd0,
      DIV_STEP  = 2'd1,
      DIV_DRIVE = 2'd2
   } div_sel_type;

   // controller to datapath
   typedef struct packed {
      logic        capture;
      logic        div_start;
      div_sel_type div_sel;
      logic        a_load;
      logic        step_load;
      logic        step_clear;
      logic        prod_load;
      logic        drv_limit;
      logic        drv_quot;
      logic        commit;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [CMD_W-1:0]   code;
      logic               active;
      logic [PHASE_W-1:0] phase;
      logic               led_big;
      logic               init_zero;
      logic               quot_zero;
      logic               div_done;
   } dp_stat_type;

   typedef struct packed {
      logic                 done;
      logic [FLAGS_W-1:0]   wflags;
      logic [ON_TIME_W-1:0] on_time;
      logic [AMB_DAC_W-1:0] amb_dac;
      logic [LED_DAC_W-1:0] led_dac;
      logic [DRIVE_W-1:0]   drive;
      logic [PHASE_W-1:0]   phase;
      logic                 worked;
   } rsp_type;

endpackage

// ----- hw/rtl/ppgagc_div.sv -----
// Restoring divider, one quotient bit per cycle, shared by all divisions.
// Standalone; used by ppgagc_dp.
module ppgagc_div #(
   parameter int NUM_W = 24,
   parameter int DEN_W = 24
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quot
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   shifted;
   logic [DEN_W:0]   diff;
   logic             fits;

   // trial subtraction for the next quotient bit
   assign shifted = {rem_ff, quo_ff[NUM_W-1]};
   assign diff    = shifted - {1'b0, den_ff};
   assign fits    = shifted >= {1'b0, den_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = num;
         den_in  = den;
         cnt_in  = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
         quo_in = {quo_ff[NUM_W-2:0], fits};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // operands
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = quo_ff;

endmodule

// ----- hw/rtl/ppgagc_ctrl.sv -----
// Sequencer for the calibration block: handshakes, division order, commit.
// Depends on ppgagc_pkg; drives ppgagc_dp through command and status structs.
module ppgagc_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   input  ppgagc_pkg::dp_stat_type stat,
   output ppgagc_pkg::ctrl_cmd_type cmd
);

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_EVAL   = 7'b0000010,
      S_DIVA   = 7'b0000100,
      S_DIVS   = 7'b0001000,
      S_MUL    = 7'b0010000,
      S_DIVD   = 7'b0100000,
      S_COMMIT = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      cmd          = '0;
      cmd.div_sel  = ppgagc_pkg::DIV_AMB;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = S_EVAL;
            end
         end
         S_EVAL: begin
            if (stat.code == ppgagc_pkg::CMD_SAMPLE && stat.active &&
                stat.phase == ppgagc_pkg::PH_CURRENT) begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = ppgagc_pkg::DIV_AMB;
               state_in      = S_DIVA;
            end else begin
               state_in = S_COMMIT;
            end
         end
         S_DIVA: begin
            if (stat.div_done) begin
               cmd.a_load = 1'b1;
               if (!stat.led_big) begin
                  cmd.drv_limit = 1'b1;
                  state_in      = S_COMMIT;
               end else if (stat.init_zero) begin
                  cmd.step_clear = 1'b1;
                  cmd.drv_limit  = 1'b1;
                  state_in       = S_COMMIT;
               end else begin
                  cmd.div_start = 1'b1;
                  cmd.div_sel   = ppgagc_pkg::DIV_STEP;
                  state_in      = S_DIVS;
               end
            end
         end
         S_DIVS: begin
            if (stat.div_done) begin
               cmd.step_load = 1'b1;
               if (stat.quot_zero) begin
                  cmd.drv_limit = 1'b1;
                  state_in      = S_COMMIT;
               end else begin
                  cmd.prod_load = 1'b1;
                  state_in      = S_MUL;
               end
            end
         end
         S_MUL: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = ppgagc_pkg::DIV_DRIVE;
            state_in      = S_DIVD;
         end
         S_DIVD: begin
            if (stat.div_done) begin
               cmd.drv_quot = 1'b1;
               state_in     = S_COMMIT;
            end
         end
         S_COMMIT: begin
            // wait for room in the output register
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   // a division only finishes while one is awaited
   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      stat.div_done |-> (state_ff == S_DIVA || state_ff == S_DIVS || state_ff == S_DIVD))
      else $error("divider finished outside a division state");

   // a committed word is offered next cycle
   a_commit_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff)
      else $error("committed word not offered");

   // a captured word is evaluated next
   a_capture_eval: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> state_ff == S_EVAL)
      else $error("captured word not evaluated");

endmodule

// ----- hw/rtl/ppgagc_dp.sv -----
// Datapath: calibration state, sample registers, shared divider and result register.
// Depends on ppgagc_pkg and ppgagc_div; sequenced by ppgagc_ctrl.
module ppgagc_dp #(
   parameter int SAMPLE_BITS = 24
) (
   input  logic                            clock,
   input  logic                            reset,
   input  ppgagc_pkg::cfg_type             cfg,
   input  logic [ppgagc_pkg::CMD_W-1:0]    req_cmd,
   input  logic [SAMPLE_BITS-1:0]          req_led,
   input  logic [SAMPLE_BITS-1:0]          req_amb,
   input  ppgagc_pkg::ctrl_cmd_type        cmd,
   output ppgagc_pkg::dp_stat_type         stat,
   output ppgagc_pkg::rsp_type             rsp
);

   localparam int NUM_W = (SAMPLE_BITS > ppgagc_pkg::PROD_W) ? SAMPLE_BITS : ppgagc_pkg::PROD_W;
   localparam int EXT_W = NUM_W + 1;
   localparam int PFULL_W = ppgagc_pkg::SCALE_W + ppgagc_pkg::SUM_W;

   // captured word
   logic [ppgagc_pkg::CMD_W-1:0] cmd_q_ff, cmd_q_in;
   logic [SAMPLE_BITS-1:0]       led_q_ff, led_q_in;
   logic [SAMPLE_BITS-1:0]       amb_q_ff, amb_q_in;

   // calibration state
   logic [ppgagc_pkg::PHASE_W-1:0]   phase_ff, phase_in;
   logic                             active_ff, active_in;
   logic [ppgagc_pkg::DRIVE_W-1:0]   drive_ff, drive_in;
   logic [ppgagc_pkg::LED_DAC_W-1:0] led_dac_ff, led_dac_in;
   logic [ppgagc_pkg::AMB_DAC_W-1:0] amb_dac_ff, amb_dac_in;
   logic [ppgagc_pkg::ON_TIME_W-1:0] on_time_ff, on_time_in;
   logic [SAMPLE_BITS-1:0]           step_ff, step_in;
   logic [ppgagc_pkg::FLAGS_W-1:0]   flags_ff, flags_in;
   logic [ppgagc_pkg::DRIVE_W-1:0]   limit_ff, limit_in;

   // working values of one word
   logic [ppgagc_pkg::AMB_DAC_W-1:0] a_ff, a_in;
   logic [ppgagc_pkg::PROD_W-1:0]    prod_ff, prod_in;
   logic [ppgagc_pkg::DRIVE_W-1:0]   dcalc_ff, dcalc_in;

   ppgagc_pkg::rsp_type rsp_ff, rsp_in;

   logic [EXT_W-1:0]               led_x, amb_x, amb_off, led_diff;
   logic                           amb_over, led_big;
   logic [ppgagc_pkg::SUM_W-1:0]   idac_sum;
   logic [PFULL_W-1:0]             prod_full;
   logic [NUM_W-1:0]               div_num;
   logic [SAMPLE_BITS-1:0]         div_den;
   logic                           div_done;
   logic [NUM_W-1:0]               div_quot;

   // sample arithmetic
   assign led_x    = EXT_W'(led_q_ff);
   assign amb_x    = EXT_W'(amb_q_ff);
   assign amb_over = amb_x > EXT_W'(ppgagc_pkg::AMB_BASE);
   assign amb_off  = amb_x - EXT_W'(ppgagc_pkg::AMB_BASE);
   assign led_big  = led_x > (amb_x + EXT_W'(ppgagc_pkg::LED_MARGIN));
   assign led_diff = led_x - amb_x;

   // 10000 * (target + ambient code)
   assign idac_sum  = ppgagc_pkg::SUM_W'(cfg.target_idac) + ppgagc_pkg::SUM_W'(a_ff);
   assign prod_full = PFULL_W'(ppgagc_pkg::SCALE) * PFULL_W'(idac_sum);

   // divider operands
   always_comb begin
      unique case (cmd.div_sel)
         ppgagc_pkg::DIV_AMB: begin
            div_num = amb_over ? amb_off[NUM_W-1:0] : '0;
            div_den = SAMPLE_BITS'(ppgagc_pkg::SCALE);
         end
         ppgagc_pkg::DIV_STEP: begin
            div_num = led_diff[NUM_W-1:0];
            div_den = SAMPLE_BITS'(cfg.init_current);
         end
         ppgagc_pkg::DIV_DRIVE: begin
            div_num = NUM_W'(prod_ff);
            div_den = step_ff;
         end
         default: begin
            div_num = '0;
            div_den = '0;
         end
      endcase
   end

   ppgagc_div #(
      .NUM_W (NUM_W),
      .DEN_W (SAMPLE_BITS)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   // working values
   always_comb begin
      cmd_q_in = cmd.capture ? req_cmd : cmd_q_ff;
      led_q_in = cmd.capture ? req_led : led_q_ff;
      amb_q_in = cmd.capture ? req_amb : amb_q_ff;
      a_in     = a_ff;
      if (cmd.a_load) begin
         a_in = (div_quot > NUM_W'(ppgagc_pkg::AMB_DAC_MAX))
              ? ppgagc_pkg::AMB_DAC_W'(ppgagc_pkg::AMB_DAC_MAX)
              : div_quot[ppgagc_pkg::AMB_DAC_W-1:0];
      end
      prod_in  = cmd.prod_load ? prod_full[ppgagc_pkg::PROD_W-1:0] : prod_ff;
      dcalc_in = dcalc_ff;
      if (cmd.drv_limit) begin
         dcalc_in = limit_ff;
      end else if (cmd.drv_quot) begin
         dcalc_in = (div_quot > NUM_W'(limit_ff)) ? limit_ff
                                                  : div_quot[ppgagc_pkg::DRIVE_W-1:0];
      end
   end

   // state update and result of one word
   always_comb begin
      phase_in   = phase_ff;
      active_in  = active_ff;
      drive_in   = drive_ff;
      led_dac_in = led_dac_ff;
      amb_dac_in = amb_dac_ff;
      on_time_in = on_time_ff;
      flags_in   = flags_ff;
      limit_in   = limit_ff;
      step_in    = step_ff;
      if (cmd.step_load) begin
         step_in = div_quot[SAMPLE_BITS-1:0];
      end else if (cmd.step_clear) begin
         step_in = '0;
      end
      rsp_in        = rsp_ff;
      rsp_in.worked = 1'b0;
      rsp_in.wflags = ppgagc_pkg::FLAGS_NONE;
      rsp_in.done   = 1'b0;
      unique case (cmd_q_ff)
         ppgagc_pkg::CMD_START: begin
            flags_in      = ppgagc_pkg::FLAGS_ALL;
            led_dac_in    = '0;
            amb_dac_in    = '0;
            on_time_in    = ppgagc_pkg::ON_TIME_W'(ppgagc_pkg::ON_TIME_INIT);
            drive_in      = cfg.init_current;
            phase_in      = ppgagc_pkg::PH_START;
            limit_in      = cfg.low_battery ? {1'b0, cfg.max_current[7:1]} : cfg.max_current;
            active_in     = 1'b1;
            rsp_in.wflags = ppgagc_pkg::FLAGS_ALL;
         end
         ppgagc_pkg::CMD_RESTART: begin
            flags_in      = ppgagc_pkg::FLAGS_ALL;
            phase_in      = ppgagc_pkg::PH_DAC;
            active_in     = 1'b1;
            rsp_in.wflags = ppgagc_pkg::FLAGS_ALL;
         end
         ppgagc_pkg::CMD_SAMPLE: begin
            if (active_ff) begin
               rsp_in.worked = 1'b1;
               unique case (phase_ff)
                  ppgagc_pkg::PH_START: phase_in = ppgagc_pkg::PH_CURRENT;
                  ppgagc_pkg::PH_CURRENT: begin
                     amb_dac_in = a_ff;
                     drive_in   = dcalc_ff;
                     led_dac_in = '0;
                     on_time_in = ppgagc_pkg::ON_TIME_W'(ppgagc_pkg::ON_TIME_CAL);
                     flags_in   = ppgagc_pkg::FLAGS_ALL;
                     phase_in   = ppgagc_pkg::PH_DAC;
                  end
                  ppgagc_pkg::PH_DAC: begin
                     // step the LED DAC toward the window, finish inside it or where the DAC cannot step on
                     if (led_x > EXT_W'(ppgagc_pkg::LED_HIGH) &&
                         led_dac_ff <= ppgagc_pkg::LED_DAC_W'(ppgagc_pkg::LED_DAC_TOP)) begin
                        led_dac_in = led_dac_ff + ppgagc_pkg::LED_DAC_W'(1);
                     end else if (led_x < EXT_W'(ppgagc_pkg::LED_LOW) && led_dac_ff != '0) begin
                        led_dac_in = led_dac_ff - ppgagc_pkg::LED_DAC_W'(1);
                     end else begin
                        phase_in = ppgagc_pkg::PH_DONE;
                     end
                     flags_in = ppgagc_pkg::FLAGS_LED_DAC;
                  end
                  default: ;
               endcase
               if (phase_in == ppgagc_pkg::PH_DONE) begin
                  active_in   = 1'b0;
                  rsp_in.done = 1'b1;
               end else begin
                  rsp_in.wflags = flags_in;
               end
            end
         end
         default: ;
      endcase
      rsp_in.phase   = phase_in;
      rsp_in.drive   = drive_in;
      rsp_in.led_dac = led_dac_in;
      rsp_in.amb_dac = amb_dac_in;
      rsp_in.on_time = on_time_in;
   end

   // calibration state, written when a word commits; the step register follows its own loads
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= ppgagc_pkg::PH_START;
         active_ff  <= 1'b0;
         drive_ff   <= '0;
         led_dac_ff <= '0;
         amb_dac_ff <= '0;
         on_time_ff <= ppgagc_pkg::ON_TIME_W'(ppgagc_pkg::ON_TIME_INIT);
         flags_ff   <= ppgagc_pkg::FLAGS_NONE;
         limit_ff   <= '0;
         step_ff    <= '0;
      end else begin
         step_ff <= step_in;
         if (cmd.commit) begin
            phase_ff   <= phase_in;
            active_ff  <= active_in;
            drive_ff   <= drive_in;
            led_dac_ff <= led_dac_in;
            amb_dac_ff <= amb_dac_in;
            on_time_ff <= on_time_in;
            flags_ff   <= flags_in;
            limit_ff   <= limit_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_q_ff <= cmd_q_in;
      led_q_ff <= led_q_in;
      amb_q_ff <= amb_q_in;
      a_ff     <= a_in;
      prod_ff  <= prod_in;
      dcalc_ff <= dcalc_in;
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign stat.code      = cmd_q_ff;
   assign stat.active    = active_ff;
   assign stat.phase     = phase_ff;
   assign stat.led_big   = led_big;
   assign stat.init_zero = (cfg.init_current == '0);
   assign stat.quot_zero = (div_quot == '0);
   assign stat.div_done  = div_done;
   assign rsp            = rsp_ff;

   // LED DAC never steps past one above its top code
   a_led_dac_range: assert property (@(posedge clock) disable iff (reset)
      led_dac_ff <= ppgagc_pkg::LED_DAC_W'(ppgagc_pkg::LED_DAC_TOP + 1))
      else $error("LED DAC code out of range");

   // a finishing word leaves the block inactive in the finished phase
   a_finish_state: assert property (@(posedge clock) disable iff (reset)
      cmd.commit && rsp_in.done |=> !active_ff && phase_ff == ppgagc_pkg::PH_DONE)
      else $error("finish did not deactivate calibration");

   // a start loads the initial drive and activates
   a_start_state: assert property (@(posedge clock) disable iff (reset)
      cmd.commit && cmd_q_ff == ppgagc_pkg::CMD_START |=>
         active_ff && phase_ff == ppgagc_pkg::PH_START && drive_ff == $past(cfg.init_current))
      else $error("start did not load initial state");

endmodule

// ----- hw/rtl/ppg_led_auto_gain_calibration.sv -----
// Top level of the LED auto gain calibration block: stream ports, register port.
// Depends on ppgagc_pkg, ppgagc_ctrl and ppgagc_dp.
//
//   channel  direction  handshake             payload
//   req      in         req_tvalid/tready     tdata led, ambient; tuser command
//   rsp      out        rsp_tvalid/tready     tdata settings and write flags; tlast done
//   csr      in/out     psel/penable/pready   four 8-bit-or-less registers at 4*i
//
// A command, an idle sample or a sample outside the current-set phase runs no division.
// A current-set sample runs up to three divisions on one shared divider at one bit a
// cycle, each over NUM_W = max(SAMPLE_BITS, 24) quotient bits.
// Reset is synchronous; there is no clearing pass.
// A result waits in the output register; the next word is accepted meanwhile and
// stalls only at its own commit until the waiting result is taken.
module ppg_led_auto_gain_calibration #(
   parameter int SAMPLE_BITS = 24
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // req: tdata = led_sample, ambient_sample, zero fill; tuser = cmd
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]    req_tdata,
   input  logic [ppgagc_pkg::CMD_W-1:0]          req_tuser,
   // rsp: tdata = worked, cal_phase, drive_current, led_offset_dac, ambient_dac,
   //      on_time, write_drive, write_led_dac, write_amb_dac, write_on_time, zero fill
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [ppgagc_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                  rsp_tlast,
   // register port
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [ppgagc_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [ppgagc_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [ppgagc_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                  csr_pready
);

   ppgagc_pkg::cfg_type      cfg_ff, cfg_in;
   ppgagc_pkg::ctrl_cmd_type ctrl_cmd;
   ppgagc_pkg::dp_stat_type  dp_stat;
   ppgagc_pkg::rsp_type      rsp_word;
   logic                     csr_wr;
   logic [ppgagc_pkg::REG_IDX_W-1:0] csr_idx;

   // register writes
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_idx    = csr_paddr[ppgagc_pkg::CSR_ADDR_W-1:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         unique case (csr_idx)
            ppgagc_pkg::REG_TARGET_IDAC:  cfg_in.target_idac  = csr_pwdata[7:0];
            ppgagc_pkg::REG_MAX_CURRENT:  cfg_in.max_current  = csr_pwdata[7:0];
            ppgagc_pkg::REG_LOW_BATTERY:  cfg_in.low_battery  = csr_pwdata[0];
            ppgagc_pkg::REG_INIT_CURRENT: cfg_in.init_current = csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_idac  <= 8'd16;
         cfg_ff.max_current  <= 8'd255;
         cfg_ff.low_battery  <= 1'b0;
         cfg_ff.init_current <= 8'd64;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // register reads
   always_comb begin
      unique case (csr_idx)
         ppgagc_pkg::REG_TARGET_IDAC:  csr_prdata = ppgagc_pkg::CSR_DATA_W'(cfg_ff.target_idac);
         ppgagc_pkg::REG_MAX_CURRENT:  csr_prdata = ppgagc_pkg::CSR_DATA_W'(cfg_ff.max_current);
         ppgagc_pkg::REG_LOW_BATTERY:  csr_prdata = ppgagc_pkg::CSR_DATA_W'(cfg_ff.low_battery);
         ppgagc_pkg::REG_INIT_CURRENT: csr_prdata = ppgagc_pkg::CSR_DATA_W'(cfg_ff.init_current);
         default:                      csr_prdata = '0;
      endcase
   end

   ppgagc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (dp_stat),
      .cmd        (ctrl_cmd)
   );

   ppgagc_dp #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_dp (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .req_cmd (req_tuser),
      .req_led (req_tdata[SAMPLE_BITS-1:0]),
      .req_amb (req_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
      .cmd     (ctrl_cmd),
      .stat    (dp_stat),
      .rsp     (rsp_word)
   );

   // result word packing, lowest field first
   assign rsp_tdata = {2'b00, rsp_word.wflags, rsp_word.on_time, rsp_word.amb_dac,
                       rsp_word.led_dac, rsp_word.drive, rsp_word.phase, rsp_word.worked};
   assign rsp_tlast = rsp_word.done;

endmodule

// ----- verif/tb_ppg_led_auto_gain_calibration.sv -----
// Self-checking testbench for ppg_led_auto_gain_calibration: stream driver, result monitor
// and register writes, with a cycle-free predictor of the calibration sequence.
// Depends on ppgagc_pkg and the top level RTL only.
module tb_ppg_led_auto_gain_calibration;
   import ppgagc_pkg::*;

   localparam int SMP_W    = 24;
   localparam int REQ_W    = ((2*SMP_W+7)/8)*8;
   localparam int SMP_MAX  = 24'hFFFFFF;
   localparam int PHASES   = 6;
   localparam int PER_SET  = 325;
   localparam int HOLD_LEN = 400;

   // kinds of LED reading offered while the offset DAC is stepping
   localparam int STEP_UP   = 0;
   localparam int STEP_DOWN = 1;
   localparam int STEP_HOLD = 2;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic [SMP_W-1:0] led;
      logic [SMP_W-1:0] amb;
   } sample_word_t;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_W-1:0]      req_tdata = '0;
   logic [CMD_W-1:0]      req_tuser = CMD_SAMPLE;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // stimulus and scoreboard
   sample_word_t word_queue[$];
   rsp_type      expected_settings[$];
   rsp_type      seen_rsp;
   rsp_type      want_rsp;
   sample_word_t next_word;
   int           idle_mode = 0;
   int           queued_words = 0;
   int           words_sent = 0;
   int           results_checked = 0;
   int           mismatch_count = 0;
   int           finished_runs = 0;
   int           hold_requests = 0;
   int           holds_granted = 0;
   int           hold_left = 0;

   // register copies
   logic [7:0] cfg_target;
   logic [7:0] cfg_max;
   logic       cfg_lowbat;
   logic [7:0] cfg_init;

   // calibration state as the block should hold it
   logic [PHASE_W-1:0]   cal_phase = PH_START;
   logic                 cal_active = 1'b0;
   logic [DRIVE_W-1:0]   drive_q = '0;
   logic [LED_DAC_W-1:0] led_dac_q = '0;
   logic [AMB_DAC_W-1:0] amb_dac_q = '0;
   logic [ON_TIME_W-1:0] on_time_q = ON_TIME_W'(ON_TIME_INIT);
   logic [SMP_W-1:0]     step_q = '0;
   logic [FLAGS_W-1:0]   flags_q = FLAGS_NONE;
   logic [DRIVE_W-1:0]   limit_q = '0;

   ppg_led_auto_gain_calibration #(.SAMPLE_BITS(SMP_W)) uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // next settings and write flags for one accepted word; updates the held state
   function automatic rsp_type calibrate(input logic [CMD_W-1:0] cmd,
                                         input logic [SMP_W-1:0] led,
                                         input logic [SMP_W-1:0] amb);
      rsp_type         r;
      longint unsigned l, m, a, d, stp;
      logic            worked;
      logic            done;
      logic [FLAGS_W-1:0] wfl;
      l = led;
      m = amb;
      worked = 1'b0;
      done = 1'b0;
      wfl = FLAGS_NONE;
      if (cmd == CMD_START) begin
         flags_q = FLAGS_ALL;
         led_dac_q = '0;
         amb_dac_q = '0;
         on_time_q = ON_TIME_W'(ON_TIME_INIT);
         drive_q = cfg_init;
         cal_phase = PH_START;
         limit_q = cfg_lowbat ? (cfg_max >> 1) : cfg_max;
         cal_active = 1'b1;
         wfl = FLAGS_ALL;
      end else if (cmd == CMD_RESTART) begin
         flags_q = FLAGS_ALL;
         cal_phase = PH_DAC;
         cal_active = 1'b1;
         wfl = FLAGS_ALL;
      end else if (cmd == CMD_SAMPLE && cal_active) begin
         case (cal_phase)
            PH_START: begin
               cal_phase = PH_CURRENT;
            end
            PH_CURRENT: begin
               a = 0;
               if (m > AMB_BASE) begin
                  a = (m - AMB_BASE) / SCALE;
                  if (a > AMB_DAC_MAX) a = AMB_DAC_MAX;
               end
               amb_dac_q = AMB_DAC_W'(a);
               if (l > m + LED_MARGIN) begin
                  stp = (cfg_init != 0) ? (l - m) / cfg_init : 0;
                  step_q = SMP_W'(stp);
                  // no measurable response per step: full drive
                  if (stp == 0) begin
                     d = limit_q;
                  end else begin
                     d = SCALE * (cfg_target + a) / stp;
                     if (d > limit_q) d = limit_q;
                  end
                  drive_q = DRIVE_W'(d);
               end else begin
                  drive_q = limit_q;
               end
               led_dac_q = '0;
               on_time_q = ON_TIME_W'(ON_TIME_CAL);
               flags_q = FLAGS_ALL;
               cal_phase = PH_DAC;
            end
            PH_DAC: begin
               if (l > LED_HIGH && led_dac_q <= LED_DAC_TOP) begin
                  led_dac_q = led_dac_q + 1'b1;
               end else if (l < LED_LOW && led_dac_q >= 1) begin
                  led_dac_q = led_dac_q - 1'b1;
               end else begin
                  cal_phase = PH_DONE;
               end
               flags_q = FLAGS_LED_DAC;
            end
            default: ;
         endcase
         worked = 1'b1;
         if (cal_phase == PH_DONE) begin
            cal_active = 1'b0;
            done = 1'b1;
            finished_runs++;
         end else begin
            wfl = flags_q;
         end
      end
      r.worked  = worked;
      r.phase   = cal_phase;
      r.drive   = drive_q;
      r.led_dac = led_dac_q;
      r.amb_dac = amb_dac_q;
      r.on_time = on_time_q;
      r.wflags  = wfl;
      r.done    = done;
      return r;
   endfunction

   function automatic int sender_idle_pct();
      case (idle_mode)
         0: return 34;
         1: return 74;
         default: return 0;
      endcase
   endfunction

   function automatic int receiver_idle_pct();
      case (idle_mode)
         0: return 74;
         1: return 34;
         default: return 0;
      endcase
   endfunction

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch on result %0d: %s", $realtime, results_checked, msg);
      mismatch_count++;
   endtask

   task automatic compare_field(input string name, input int unsigned got,
                                input int unsigned want);
      if (got != want)
         report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
   endtask

   // request side: present the next queued word, predict on each accepted one
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_settings.push_back(calibrate(req_tuser, req_tdata[SMP_W-1:0],
                                                  req_tdata[2*SMP_W-1:SMP_W]));
            words_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (word_queue.size() != 0 && $urandom_range(99, 0) >= sender_idle_pct()) begin
               next_word = word_queue.pop_front();
               req_tvalid <= 1'b1;
               req_tuser <= next_word.cmd;
               req_tdata <= {next_word.amb, next_word.led};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // long output hold-off, counted here
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         holds_granted <= 0;
      end else if (holds_granted != hold_requests) begin
         hold_left <= HOLD_LEN;
         holds_granted <= holds_granted + 1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // result side: unpack tdata, compare against the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen_rsp.worked  = rsp_tdata[0];
            seen_rsp.phase   = rsp_tdata[2:1];
            seen_rsp.drive   = rsp_tdata[10:3];
            seen_rsp.led_dac = rsp_tdata[17:11];
            seen_rsp.amb_dac = rsp_tdata[27:18];
            seen_rsp.on_time = rsp_tdata[33:28];
            seen_rsp.wflags  = rsp_tdata[37:34];
            seen_rsp.done    = rsp_tlast;
            if (expected_settings.size() == 0) begin
               report_mismatch("result word with no prediction outstanding");
            end else begin
               want_rsp = expected_settings.pop_front();
               compare_field("worked", seen_rsp.worked, want_rsp.worked);
               compare_field("cal_phase", seen_rsp.phase, want_rsp.phase);
               compare_field("drive_current", seen_rsp.drive, want_rsp.drive);
               compare_field("led_offset_dac", seen_rsp.led_dac, want_rsp.led_dac);
               compare_field("ambient_dac", seen_rsp.amb_dac, want_rsp.amb_dac);
               compare_field("on_time", seen_rsp.on_time, want_rsp.on_time);
               compare_field("write flags", seen_rsp.wflags, want_rsp.wflags);
               compare_field("done_res", seen_rsp.done, want_rsp.done);
            end
            results_checked++;
         end
         rsp_tready <= (hold_left == 0) && ($urandom_range(99, 0) >= receiver_idle_pct());
      end
   end

   // one register write: setup then access cycle
   task automatic write_setting(input logic [REG_IDX_W-1:0] idx, input logic [7:0] val);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= {24'd0, val};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         REG_TARGET_IDAC:  cfg_target = val;
         REG_MAX_CURRENT:  cfg_max = val;
         REG_LOW_BATTERY:  cfg_lowbat = val[0];
         REG_INIT_CURRENT: cfg_init = val;
         default: ;
      endcase
   endtask

   task automatic apply_settings(input logic [7:0] target, input logic [7:0] max_cur,
                                 input logic lowbat, input logic [7:0] init_cur);
      write_setting(REG_TARGET_IDAC, target);
      write_setting(REG_MAX_CURRENT, max_cur);
      write_setting(REG_LOW_BATTERY, {7'd0, lowbat});
      write_setting(REG_INIT_CURRENT, init_cur);
   endtask

   task automatic push_word(input logic [CMD_W-1:0] cmd, input logic [SMP_W-1:0] led,
                            input logic [SMP_W-1:0] amb, input bit counts);
      word_queue.push_back('{cmd: cmd, led: led, amb: amb});
      if (counts) queued_words++;
   endtask

   // ambient reading for the current-set sample: below base, in range, saturating, any
   function automatic logic [SMP_W-1:0] ambient_for_current();
      case ($urandom_range(3, 0))
         0: return $urandom_range(AMB_BASE, 0);
         1: return $urandom_range(AMB_BASE + SCALE*AMB_DAC_MAX, AMB_BASE + 1);
         2: return $urandom_range(SMP_MAX, AMB_BASE + SCALE*AMB_DAC_MAX + 1);
         default: return $urandom;
      endcase
   endfunction

   // LED reading relative to ambient: within margin, just over it, well over it, any
   function automatic logic [SMP_W-1:0] led_for_current(input logic [SMP_W-1:0] amb);
      longint unsigned v;
      case ($urandom_range(3, 0))
         0: v = $urandom_range(amb + LED_MARGIN, 0);
         1: v = amb + LED_MARGIN + 1 + $urandom_range(500, 0);
         2: v = amb + LED_MARGIN + 1 + $urandom_range(SMP_MAX, 0);
         default: v = $urandom_range(SMP_MAX, 0);
      endcase
      if (v > SMP_MAX) v = SMP_MAX;
      return SMP_W'(v);
   endfunction

   function automatic logic [SMP_W-1:0] led_for_step(input int kind);
      case (kind)
         STEP_UP:
            return ($urandom_range(9, 0) == 0) ? LED_HIGH + 1 : $urandom_range(SMP_MAX, LED_HIGH + 1);
         STEP_DOWN:
            return ($urandom_range(9, 0) == 0) ? LED_LOW - 1 : $urandom_range(LED_LOW - 1, 0);
         default:
            case ($urandom_range(9, 0))
               0: return LED_LOW;
               1: return LED_HIGH;
               default: return $urandom_range(LED_HIGH, LED_LOW);
            endcase
      endcase
   endfunction

   // one calibration run with random content, occasionally noise or cut short
   task automatic add_sequence();
      logic [SMP_W-1:0] amb;
      int               steps;
      bit               long_run;
      if ($urandom_range(99, 0) < 8) begin
         push_word(($urandom_range(9, 0) == 0) ? CMD_UNUSED : CMD_SAMPLE,
                   $urandom, $urandom, 1'b0);
         return;
      end
      if ($urandom_range(99, 0) < 80) begin
         push_word(CMD_START, $urandom, $urandom, 1'b1);
         push_word(CMD_SAMPLE, $urandom, $urandom, 1'b1);
         amb = ambient_for_current();
         push_word(CMD_SAMPLE, led_for_current(amb), amb, 1'b1);
      end else begin
         push_word(CMD_RESTART, $urandom, $urandom, 1'b1);
      end
      // rarely drive the offset DAC all the way to its top code
      long_run = ($urandom_range(99, 0) < 3);
      steps = long_run ? $urandom_range(130, 100) : $urandom_range(8, 0);
      for (int k = 0; k < steps; k++)
         push_word(CMD_SAMPLE,
                   led_for_step((long_run || $urandom_range(99, 0) < 55) ? STEP_UP : STEP_DOWN),
                   $urandom, 1'b1);
      if ($urandom_range(9, 0) != 0)
         push_word(CMD_SAMPLE, led_for_step(STEP_HOLD), $urandom, 1'b1);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      for (int ph = 0; ph < PHASES; ph++) begin
         idle_mode = ph / 2;
         case (ph)
            0: apply_settings(8'd16, 8'd255, 1'b0, 8'd200);
            1: apply_settings(8'd255, 8'd0, 1'b1, 8'd1);
            2: apply_settings(8'd0, 8'd255, 1'b1, 8'd255);
            default: apply_settings($urandom_range(255, 0), $urandom_range(255, 0),
                                    $urandom_range(1, 0), $urandom_range(255, 1));
         endcase
         if (ph == 0) begin
            // idle sample, unused code, restart from reset and a finish in the window
            push_word(CMD_SAMPLE, '0, '0, 1'b1);
            push_word(CMD_UNUSED, SMP_MAX, SMP_MAX, 1'b1);
            push_word(CMD_RESTART, '0, '0, 1'b1);
            push_word(CMD_UNUSED, '0, SMP_MAX, 1'b1);
            push_word(CMD_SAMPLE, LED_HIGH, '0, 1'b1);
            push_word(CMD_SAMPLE, SMP_MAX, SMP_MAX, 1'b1);
            // ambient saturation, LED within margin, DAC up and down to zero
            push_word(CMD_START, '0, '0, 1'b1);
            push_word(CMD_SAMPLE, SMP_MAX, SMP_MAX, 1'b1);
            push_word(CMD_SAMPLE, SMP_MAX, SMP_MAX, 1'b1);
            push_word(CMD_SAMPLE, SMP_MAX, '0, 1'b1);
            push_word(CMD_SAMPLE, LED_HIGH + 1, '0, 1'b1);
            push_word(CMD_SAMPLE, '0, '0, 1'b1);
            push_word(CMD_SAMPLE, LED_LOW - 1, '0, 1'b1);
            push_word(CMD_SAMPLE, '0, '0, 1'b1);
            // large difference, then restart mid-run
            push_word(CMD_START, '0, '0, 1'b1);
            push_word(CMD_SAMPLE, '0, '0, 1'b1);
            push_word(CMD_SAMPLE, SMP_MAX, '0, 1'b1);
            push_word(CMD_RESTART, '0, '0, 1'b1);
            push_word(CMD_SAMPLE, LED_LOW, '0, 1'b1);
            // zero step: difference below the initial current
            push_word(CMD_START, '0, '0, 1'b1);
            push_word(CMD_SAMPLE, '0, '0, 1'b1);
            push_word(CMD_SAMPLE, AMB_BASE + 151, AMB_BASE + 1, 1'b1);
            push_word(CMD_SAMPLE, LED_LOW - 1, '0, 1'b1);
            // drive clamped to the limit
            push_word(CMD_START, '0, '0, 1'b1);
            push_word(CMD_SAMPLE, '0, '0, 1'b1);
            push_word(CMD_SAMPLE, AMB_BASE + SCALE + 400, AMB_BASE + SCALE, 1'b1);
            push_word(CMD_SAMPLE, LED_HIGH - 1, '0, 1'b1);
         end
         if (ph == 4) begin
            @(negedge clock);
            hold_requests++;
         end
         queued_words = 0;
         while (queued_words < PER_SET) add_sequence();
         // wait until every word is through, then let the pipeline settle
         @(negedge clock);
         while (word_queue.size() != 0 || req_tvalid || expected_settings.size() != 0)
            @(negedge clock);
         repeat (100) @(posedge clock);
      end
      $display("checked %0d results for %0d words; %0d calibration runs ran to completion",
               results_checked, words_sent, finished_runs);
      $display("%0d register settings incl. extremes, stalls on both sides, one long hold-off",
               PHASES);
      if (mismatch_count == 0 && expected_settings.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #8000000;
      $display("simulation failed");
      $finish;
   end

endmodule
